@@ hdl/scpa_pkg.sv @@
`timescale 1ns / 1ps

package scpa_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned NUM_POOLS_DEF  = 8;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned MIN_SHIFT_DEF  = 3;
  localparam int unsigned ADDR_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int unsigned PAGE_W    = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned IN_ADDR_W = 32;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned STATUS_W   = 3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_UNKNOWN   = 3'd3,
    STAT_NULL      = 3'd4
  } scpa_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } scpa_state_e;

  // Link memory command from the engine.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } lnk_cmd_t;

endpackage

@@ hdl/scpa_link_mem.sv @@
`timescale 1ns / 1ps

module scpa_link_mem
  import scpa_pkg::*;
#(
  parameter int unsigned NUM_POOLS  = NUM_POOLS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MIN_SHIFT  = MIN_SHIFT_DEF,
  localparam int unsigned MAX_CHUNKS = PAGE_BYTES >> MIN_SHIFT,
  localparam int unsigned CW         = $clog2(MAX_CHUNKS),
  localparam int unsigned LW         = CW + 1,
  localparam int unsigned POOL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
  localparam int unsigned MEM_AW     = POOL_W + CW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lnk_cmd_t          cmd_i,
  input  logic [MEM_AW-1:0] addr_i,
  input  logic [LW-1:0]     wdata_i,
  output logic [LW-1:0]     rdata_o,
  output logic              ready_o
);

  localparam int unsigned DEPTH = 1 << MEM_AW;
  localparam logic [LW-1:0] LINK_NULL = LW'(MAX_CHUNKS);

  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rdata_q;

  logic              clr_busy_q, clr_busy_d;
  logic [MEM_AW-1:0] clr_addr_q, clr_addr_d;

  logic [POOL_W-1:0] clr_pool;
  logic [LW-1:0]     clr_count;
  logic [LW-1:0]     clr_succ;
  logic [LW-1:0]     clr_value;

  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [LW-1:0]     wdata;

  // After reset every entry is swept once to hold its successor in the
  // ascending list of its pool, or null for the last chunk.
  always_comb begin
    clr_pool  = clr_addr_q[MEM_AW-1:CW];
    clr_count = LW'(MAX_CHUNKS) >> clr_pool;
    clr_succ  = {1'b0, clr_addr_q[CW-1:0]} + LW'(1);
    clr_value = (clr_succ < clr_count) ? clr_succ : LINK_NULL;

    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + MEM_AW'(1);
      if (clr_addr_q == {MEM_AW{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end

    we    = clr_busy_q ? 1'b1 : cmd_i.wr_en;
    waddr = clr_busy_q ? clr_addr_q : addr_i;
    wdata = clr_busy_q ? clr_value : wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

@@ hdl/scpa_engine.sv @@
`timescale 1ns / 1ps

module scpa_engine
  import scpa_pkg::*;
#(
  parameter int unsigned NUM_POOLS  = NUM_POOLS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MIN_SHIFT  = MIN_SHIFT_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
  localparam int unsigned PS         = $clog2(PAGE_BYTES + 1) - 1,
  localparam int unsigned MAX_CHUNKS = PAGE_BYTES >> MIN_SHIFT,
  localparam int unsigned CW         = $clog2(MAX_CHUNKS),
  localparam int unsigned LW         = CW + 1,
  localparam int unsigned POOL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
  localparam int unsigned MEM_AW     = POOL_W + CW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [NUM_POOLS-1:0][PAGE_W-1:0]  page_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_DATA_W-1:0]              s_axis_tdata,
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_ADDR_W-1:0]             m_axis_tdata,
  output logic [STATUS_W-1:0]               m_axis_tuser,
  output lnk_cmd_t                          lnk_cmd_o,
  output logic [MEM_AW-1:0]                 lnk_addr_o,
  output logic [LW-1:0]                     lnk_wdata_o,
  input  logic [LW-1:0]                     lnk_rdata_i,
  input  logic                              lnk_ready_i
);

  localparam logic [LW-1:0] LINK_NULL = LW'(MAX_CHUNKS);
  localparam int unsigned OUT_AW = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
  localparam int unsigned OFF_W  = CW + MIN_SHIFT;
  localparam int unsigned FULL_W = PAGE_W + PS + 1;
  localparam int unsigned FA_W   = FULL_W + OUT_ADDR_W;
  localparam logic [IN_ADDR_W-1:0] IN_MASK = (ADDR_BITS >= IN_ADDR_W) ? '1 :
      IN_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  scpa_state_e state_q, state_d;

  logic [CW-1:0] head_q [NUM_POOLS];
  logic [NUM_POOLS-1:0] empty_q;

  // Item held between acceptance and delivery.
  logic                  pop_q;
  logic [POOL_W-1:0]     pool_q;
  logic [OUT_ADDR_W-1:0] gaddr_q;
  scpa_status_e          status_q;

  logic                  m_valid_q;
  logic [OUT_ADDR_W-1:0] m_data_q;
  scpa_status_e          m_status_q;

  // Decode of the offered word.
  logic                  kind;
  logic [SIZE_W-1:0]     req_size;
  logic [IN_ADDR_W-1:0]  in_addr;
  logic [IN_ADDR_W-1:0]  page_in;
  logic                  a_found, f_hit, f_null;
  logic [POOL_W-1:0]     a_pool, f_pool, sel_pool;
  logic [CW-1:0]         head_sel, free_idx;
  logic                  empty_sel;
  logic [OFF_W-1:0]      chunk_off;
  logic [FA_W-1:0]       full_addr;
  logic [OUT_ADDR_W-1:0] dec_gaddr;
  scpa_status_e          dec_status;
  logic                  dec_pop, dec_push;

  logic accept, out_free, load_out;

  always_comb begin
    kind     = s_axis_tuser;
    req_size = s_axis_tdata[SIZE_W-1:0];
    in_addr  = s_axis_tdata[SIZE_W+IN_ADDR_W-1:SIZE_W] & IN_MASK;
    page_in  = in_addr >> PS;

    // Lowest class that fits, and lowest pool whose page matches.
    a_found = 1'b0;
    a_pool  = '0;
    f_hit   = 1'b0;
    f_pool  = '0;
    for (int i = NUM_POOLS - 1; i >= 0; i--) begin
      if (32'(req_size) <= (32'd1 << (MIN_SHIFT + i))) begin
        a_found = 1'b1;
        a_pool  = POOL_W'(i);
      end
      if (IN_ADDR_W'(page_i[i]) == page_in) begin
        f_hit  = 1'b1;
        f_pool = POOL_W'(i);
      end
    end
    f_null = (in_addr == '0);

    sel_pool  = (kind == KIND_FREE) ? f_pool : a_pool;
    head_sel  = head_q[sel_pool];
    empty_sel = empty_q[sel_pool];

    free_idx  = CW'(in_addr[PS-1:MIN_SHIFT] >> sel_pool);
    chunk_off = {head_sel, {MIN_SHIFT{1'b0}}} << sel_pool;
    // When the page is not a power of two the chunk offset can reach past it,
    // so the offset is added rather than concatenated.
    full_addr = FA_W'({page_i[sel_pool], {PS{1'b0}}}) + FA_W'(chunk_off);

    dec_pop  = 1'b0;
    dec_push = 1'b0;
    if (kind == KIND_ALLOC) begin
      if (!a_found) begin
        dec_status = STAT_TOO_LARGE;
      end else if (empty_sel) begin
        dec_status = STAT_EMPTY;
      end else begin
        dec_status = STAT_OK;
        dec_pop    = 1'b1;
      end
    end else begin
      if (f_null) begin
        dec_status = STAT_NULL;
      end else if (!f_hit) begin
        dec_status = STAT_UNKNOWN;
      end else begin
        dec_status = STAT_OK;
        dec_push   = 1'b1;
      end
    end
    dec_gaddr = dec_pop ? OUT_ADDR_W'(full_addr[OUT_AW-1:0]) : '0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready   = 1'b0;
    load_out        = 1'b0;
    out_free        = !m_valid_q || m_axis_tready;
    unique case (state_q)
      ST_IDLE: s_axis_tready = lnk_ready_i;
      ST_BUSY: load_out      = out_free;
      default: ;
    endcase
    accept          = s_axis_tready && s_axis_tvalid;
    lnk_cmd_o.rd_en = accept && dec_pop;
    lnk_cmd_o.wr_en = accept && dec_push;
    lnk_addr_o      = {sel_pool, dec_pop ? head_sel : free_idx};
    lnk_wdata_o     = empty_sel ? LINK_NULL : {1'b0, head_sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      pop_q     <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        head_q[i]  <= '0;
        // A pool whose chunk exceeds the page starts with no chunks.
        empty_q[i] <= (MIN_SHIFT + i > PS);
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        pop_q <= dec_pop;
      end
      if (accept && dec_push) begin
        head_q[sel_pool]  <= free_idx;
        empty_q[sel_pool] <= 1'b0;
      end
      if (load_out && pop_q) begin
        if (lnk_rdata_i >= LINK_NULL) begin
          head_q[pool_q]  <= '0;
          empty_q[pool_q] <= 1'b1;
        end else begin
          head_q[pool_q] <= lnk_rdata_i[CW-1:0];
        end
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pool_q   <= sel_pool;
      gaddr_q  <= dec_gaddr;
      status_q <= dec_status;
    end
    if (load_out) begin
      m_data_q   <= gaddr_q;
      m_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_BUSY)
    else $error("accepted word did not enter the busy state");

  a_read_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lnk_cmd_o.rd_en |=> pop_q && state_q == ST_BUSY)
    else $error("link read issued without a pending pop");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lnk_ready_i |-> !s_axis_tready)
    else $error("input taken during link memory initialization");

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lnk_cmd_o.rd_en && lnk_cmd_o.wr_en))
    else $error("link read and write in the same cycle");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && status_q != STAT_OK |=> m_axis_tdata == '0)
    else $error("nonzero address delivered with a failure status");

endmodule

@@ hdl/size_class_pool_allocator.sv @@
`timescale 1ns / 1ps

// Size-class pool allocator with eight segregated free lists.
// The input stream carries one request per word: tuser selects allocate (0)
// or free (1); tdata holds the request size and the chunk address. The output
// stream returns one word per request: tdata is the granted chunk address
// (zero unless an allocation succeeds) and tuser the status code.
// Page registers are written through the cfg channel, which is always ready;
// index i writes the page number of pool i.
// The request is registered at the accepting edge; its result word moves to
// the output register once that register is free, and the next request is
// taken only then. An allocation needs the link memory read of the popped
// chunk, whose registered read data returns in the cycle after acceptance.
// After reset the link memory is initialized by a sweep over all
// 2^(POOL_W + CW) entries, with POOL_W the pool index width (at least one bit)
// and CW = ceil(log2(PAGE_BYTES >> MIN_SHIFT)) (4096 entries at the default
// settings); no request is accepted until it completes.
// The result sits in an output register: while the receiver stalls, the
// block still accepts one more request and holds its result internally,
// then waits until the output word is taken.
module size_class_pool_allocator
  import scpa_pkg::*;
#(
  parameter int unsigned NUM_POOLS  = NUM_POOLS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int unsigned MIN_SHIFT  = MIN_SHIFT_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [PAGE_W-1:0]     cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_size[15:0], chunk_address[47:16]
  input  logic                  s_axis_tuser,   // kind[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_ADDR_W-1:0] m_axis_tdata,   // granted_address[31:0]
  output logic [STATUS_W-1:0]   m_axis_tuser    // status[2:0]
);

  localparam int unsigned CW     = $clog2(PAGE_BYTES >> MIN_SHIFT);
  localparam int unsigned LW     = CW + 1;
  localparam int unsigned POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned MEM_AW = POOL_W + CW;

  logic [NUM_POOLS-1:0][PAGE_W-1:0] page_q;

  lnk_cmd_t          lnk_cmd;
  logic [MEM_AW-1:0] lnk_addr;
  logic [LW-1:0]     lnk_wdata;
  logic [LW-1:0]     lnk_rdata;
  logic              lnk_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        page_q[i] <= PAGE_W'(i + 1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Indexes past the last pool are dropped.
      for (int i = 0; i < NUM_POOLS; i++) begin
        if (32'(cfg_index_i) == i) begin
          page_q[i] <= cfg_data_i;
        end
      end
    end
  end

  scpa_engine #(
    .NUM_POOLS  (NUM_POOLS),
    .PAGE_BYTES (PAGE_BYTES),
    .MIN_SHIFT  (MIN_SHIFT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .page_i        (page_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .lnk_cmd_o     (lnk_cmd),
    .lnk_addr_o    (lnk_addr),
    .lnk_wdata_o   (lnk_wdata),
    .lnk_rdata_i   (lnk_rdata),
    .lnk_ready_i   (lnk_ready)
  );

  scpa_link_mem #(
    .NUM_POOLS  (NUM_POOLS),
    .PAGE_BYTES (PAGE_BYTES),
    .MIN_SHIFT  (MIN_SHIFT)
  ) u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lnk_cmd),
    .addr_i  (lnk_addr),
    .wdata_i (lnk_wdata),
    .rdata_o (lnk_rdata),
    .ready_o (lnk_ready)
  );

endmodule

@@ bench/pool_alloc_checker.sv @@
`timescale 1ns / 1ps

// Watches the config, request and result channels of the allocator. It keeps
// its own copy of the page registers and the free lists, works out the grant
// for every accepted request and compares each result word against the oldest
// grant still waiting.
module pool_alloc_checker
  import scpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [PAGE_W-1:0]     cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_ADDR_W-1:0] m_axis_tdata,
  input  logic [STATUS_W-1:0]   m_axis_tuser,
  output int                    fail_count,
  output int                    pending
);

  localparam int POOLS      = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int LOW_SHIFT  = 3;
  localparam int CHUNKS     = 512;
  localparam logic [10:0] LINK_NULL = 11'd512;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] addr;
    scpa_status_e          status;
  } grant_t;

  grant_t           grants_due[$];
  logic [PAGE_W-1:0] page_reg[POOLS];
  logic [9:0]       head[POOLS];
  logic             empty[POOLS];
  logic [10:0]      link[POOLS][CHUNKS];

  function automatic grant_t serve_request(logic kind, logic [SIZE_W-1:0] size,
                                           logic [IN_ADDR_W-1:0] addr);
    grant_t      r;
    int          p;
    int          sel;
    logic [9:0]  h;
    logic [10:0] nx;
    logic [9:0]  idx;
    r.addr   = '0;
    r.status = STAT_OK;
    sel      = -1;
    if (kind == KIND_ALLOC) begin
      // Scan downward so the smallest fitting class wins.
      for (p = POOLS - 1; p >= 0; p--)
        if ({16'b0, size} <= (32'd1 << (LOW_SHIFT + p))) sel = p;
      if (sel < 0) begin
        r.status = STAT_TOO_LARGE;
      end else if (empty[sel]) begin
        r.status = STAT_EMPTY;
      end else begin
        h      = head[sel];
        nx     = link[sel][h];
        r.addr = {page_reg[sel], 12'b0} + (32'(h) << (LOW_SHIFT + sel));
        if (nx >= LINK_NULL) begin
          empty[sel] = 1'b1;
          head[sel]  = '0;
        end else begin
          head[sel] = nx[9:0];
        end
      end
    end else if (addr == '0) begin
      r.status = STAT_NULL;
    end else begin
      // Lowest-numbered pool takes the free when pages are shared.
      for (p = POOLS - 1; p >= 0; p--)
        if (page_reg[p] == addr[31:PAGE_SHIFT]) sel = p;
      if (sel < 0) begin
        r.status = STAT_UNKNOWN;
      end else begin
        idx = 10'(addr[PAGE_SHIFT-1:0] >> (LOW_SHIFT + sel));
        link[sel][idx] = empty[sel] ? LINK_NULL : {1'b0, head[sel]};
        head[sel]  = idx;
        empty[sel] = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    int     p;
    int     c;
    if (!rst_ni) begin
      for (p = 0; p < POOLS; p++) begin
        page_reg[p] = PAGE_W'(p + 1);
        head[p]     = '0;
        empty[p]    = 1'b0;
        for (c = 0; c < CHUNKS; c++)
          link[p][c] = (c + 1 < (CHUNKS >> p)) ? 11'(c + 1) : LINK_NULL;
      end
      grants_due.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) page_reg[cfg_index_i] = cfg_data_i;
      // The word leaving now belongs to an earlier request, so compare first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result word: granted_address %h, status %0d",
                 m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          if (m_axis_tdata !== want.addr) begin
            $error("granted_address: expected %h, actual %h", want.addr, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        grants_due.push_back(serve_request(s_axis_tuser, s_axis_tdata[15:0],
                                           s_axis_tdata[47:16]));
      pending = grants_due.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import scpa_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 215;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [PAGE_W-1:0]     cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = KIND_ALLOC;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_ADDR_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  int fail_count;
  int pending;
  int tx_idle_pct   = 11;
  int rx_idle_pct   = 75;
  int hold_requests = 0;
  int hold_served   = 0;
  int stall_cycles  = 0;
  logic [PAGE_W-1:0] page_copy[8];

  size_class_pool_allocator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pool_alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, or one long hold-off when one is asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_served < hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_served++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one request word and returns at the edge that accepts it.
  task automatic send_request(logic kind, logic [SIZE_W-1:0] size,
                              logic [IN_ADDR_W-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, size};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic alloc(logic [SIZE_W-1:0] size);
    send_request(KIND_ALLOC, size, $urandom);
  endtask

  task automatic release_chunk(logic [IN_ADDR_W-1:0] addr);
    send_request(KIND_FREE, SIZE_W'($urandom), addr);
  endtask

  // Stops offering and waits until every grant has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_pages();
    int p;
    for (p = 0; p < 8; p++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(p);
      cfg_data_i  <= page_copy[p];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly sized allocations and frees into configured pages, with a share
  // of raw sizes and addresses that exercise every field bit.
  task automatic random_request();
    int                    pick;
    int                    k;
    logic [SIZE_W-1:0]     size;
    logic [11:0]           offset;
    pick = $urandom_range(99);
    k    = $urandom_range(7);
    if (pick < 45) begin
      if (k == 0) size = SIZE_W'($urandom_range(8));
      else size = SIZE_W'($urandom_range((1 << (k + 3)), (1 << (k + 2)) + 1));
      alloc(size);
    end else if (pick < 50) begin
      alloc(SIZE_W'($urandom));
    end else if (pick < 88) begin
      offset = 12'($urandom);
      if ($urandom_range(3) != 0) offset = offset & ~12'((1 << (k + 3)) - 1);
      release_chunk({page_copy[k], offset});
    end else if (pick < 90) begin
      release_chunk('0);
    end else begin
      release_chunk($urandom);
    end
  endtask

  initial begin
    int phase;
    int n;
    int p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (p = 0; p < 8; p++) page_copy[p] = PAGE_W'(p + 1);

    // Size classes and their edges under the reset pages.
    alloc(16'd0);
    alloc(16'd8);
    alloc(16'd9);
    alloc(16'd1024);
    alloc(16'd1025);
    alloc(16'hFFFF);
    release_chunk(32'h0000_0000);
    release_chunk(32'hFFFF_FFFF);
    // Misaligned free, then the same chunk freed twice.
    release_chunk(32'h0000_1003);
    release_chunk(32'h0000_1003);
    // The largest pool has four chunks; the last call finds it empty.
    repeat (4) alloc(16'd1000);

    settle();
    page_copy = '{20'h00000, 20'hFFFFF, 20'h12345, 20'h12345,
                  20'h00005, 20'h00006, 20'h00007, 20'h00008};
    load_pages();
    // A zero address stays a null free even with a pool on page zero.
    release_chunk(32'h0000_0000);
    release_chunk(32'h0000_0010);
    alloc(16'd1);
    release_chunk(32'hFFFF_F008);
    // Shared page: pool two takes the free, pool three still allocates there.
    release_chunk(32'h1234_5040);
    alloc(16'd64);
    release_chunk(32'h0000_8000);
    alloc(16'd1024);

    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        tx_idle_pct = 75;
        rx_idle_pct = 11;
        settle();
        for (p = 0; p < 8; p++) page_copy[p] = PAGE_W'($urandom);
        page_copy[5] = page_copy[4];
        load_pages();
      end else if (phase == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        settle();
        for (p = 0; p < 8; p++) page_copy[p] = 20'hFFFFF - PAGE_W'(p);
        page_copy[7] = 20'h00001;
        load_pages();
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 20) hold_requests++;
        random_request();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
